>>> hw/rtl/mu7_pkg.sv
// ----------------------------------------------------------------------------
// mu7_pkg: shared types and helpers for the modified UTF-7 decoder
// Decode modes, result kinds, error codes, the command record passed from
// the front end to the back end, and the small decode/encode functions.
// ----------------------------------------------------------------------------
package mu7_pkg;

	// Character constants
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Bits per code point, bit collector width
	localparam int CP_BITS  = 16;
	localparam int BUF_BITS = 22;

	// Command queue depth
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_AMP   = 2'd1,
		MODE_B64   = 2'd2
	} mu7_mode_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} mu7_kind_t;

	typedef enum logic [1:0] {
		ERR_CHAR = 2'd0,
		ERR_B64  = 2'd1,
		ERR_BITS = 2'd2,
		ERR_OVER = 2'd3
	} mu7_err_t;

	// One queued request: a code point of nbytes UTF-8 bytes, an end mark or an error
	typedef struct packed {
		mu7_kind_t   kind;
		mu7_err_t    err;
		logic [15:0] cp;
		logic [1:0]  nbytes;
	} mu7_cmd_t;

	// Base64 digit decode, returns {valid, value}
	function automatic logic [6:0] mu7_b64_decode(logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = {1'b1, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = {1'b1, 6'(c - 8'h47)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 6'(c + 8'd4)};
		end else if (c == CH_PLUS) begin
			r = {1'b1, 6'd62};
		end else if (c == CH_COMMA) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

	// Byte idx of the UTF-8 form of cp, which takes nb bytes
	function automatic logic [7:0] mu7_utf8_byte(logic [15:0] cp, logic [1:0] nb,
		logic [1:0] idx);
		logic [7:0] b;
		case (nb)
			2'd2: begin
				b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			end
			2'd3: begin
				case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				b = cp[7:0];
			end
		endcase
		return b;
	endfunction

endpackage

>>> hw/rtl/mu7_if.sv
// ----------------------------------------------------------------------------
// mu7 channel interfaces
// Valid/ready channels for input text, results and the limit register.
// ----------------------------------------------------------------------------
interface mu7_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

interface mu7_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic [1:0] error_code;
	logic       last;
	modport source(output valid, output out_byte, output kind, output error_code,
		output last, input ready);
	modport sink(input valid, input out_byte, input kind, input error_code,
		input last, output ready);
endinterface

interface mu7_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] output_limit;
	modport source(output valid, output output_limit, input ready);
	modport sink(input valid, input output_limit, output ready);
endinterface

>>> hw/rtl/mu7_front.sv
// ----------------------------------------------------------------------------
// mu7_front: input classifier and decode state
// Takes one byte per cycle while the queue has room, tracks mode, base64
// bits and output count, and queues one request per byte that produces results.
// ----------------------------------------------------------------------------
module mu7_front (
	input  logic              clk,
	input  logic              arst_n,
	mu7_byte_if.sink          text,
	mu7_cfg_if.sink           cfg,
	input  logic              full,
	output logic              push,
	output mu7_pkg::mu7_cmd_t cmd
);
	import mu7_pkg::*;

	mu7_mode_t            mode_q, mode_n;
	logic [BUF_BITS-1:0]  buf_q, buf_n;
	logic [4:0]           cnt_q, cnt_n;
	logic [15:0]          bw_q, bw_n;
	logic                 err_seen_q, err_seen_n;
	logic [15:0]          limit_q;

	logic [7:0]           c;
	logic                 accept, is_zero, is_dash, is_amp, is_ctl;
	logic [6:0]           b64_dec;
	logic                 b64_ok;
	logic [5:0]           b64_v;
	logic [BUF_BITS-1:0]  base_buf, new_buf, leftover;
	logic [4:0]           base_cnt, new_cnt;
	logic                 cp_full, bits_ok;
	logic [2:0]           shamt;
	logic [15:0]          cp;
	logic [1:0]           cp_nb;
	logic                 room_plain, room_cp, room_end;

	assign text.ready = !full;
	assign cfg.ready  = 1'b1;
	assign accept     = text.valid && !full;

	// Classify the byte and precompute the base64 step and room checks
	always_comb begin
		c        = text.in_byte;
		is_zero  = (c == 8'h00);
		is_dash  = (c == CH_DASH);
		is_amp   = (c == CH_AMP);
		is_ctl   = (c < CH_SPACE) || c[7];
		b64_dec  = mu7_b64_decode(c);
		b64_ok   = b64_dec[6];
		b64_v    = b64_dec[5:0];
		base_buf = (mode_q == MODE_AMP) ? '0 : buf_q;
		base_cnt = (mode_q == MODE_AMP) ? 5'd0 : cnt_q;
		new_buf  = {base_buf[BUF_BITS-7:0], b64_v};
		new_cnt  = base_cnt + 5'd6;
		cp_full  = (new_cnt >= 5'(CP_BITS));
		shamt    = 3'(new_cnt - 5'(CP_BITS));
		cp       = 16'(new_buf >> shamt);
		cp_nb    = (cp < 16'h0080) ? 2'd1 : ((cp < 16'h0800) ? 2'd2 : 2'd3);
		room_plain = ({1'b0, bw_q} + 17'd1) < {1'b0, limit_q};
		room_cp    = ({1'b0, bw_q} + 17'(cp_nb) + 17'd1) < {1'b0, limit_q};
		room_end   = bw_q < limit_q;
		leftover   = buf_q & ((22'd1 << cnt_q) - 22'd1);
		bits_ok    = (leftover == '0);
	end

	// Next decode state
	always_comb begin
		mode_n     = mode_q;
		buf_n      = buf_q;
		cnt_n      = cnt_q;
		bw_n       = bw_q;
		err_seen_n = err_seen_q;
		if (accept) begin
			if (err_seen_q) begin
				if (is_zero) begin
					mode_n = MODE_PLAIN; buf_n = '0; cnt_n = '0; bw_n = '0; err_seen_n = 1'b0;
				end
			end else if (mode_q == MODE_AMP && is_dash) begin
				mode_n = MODE_PLAIN;
				if (room_plain) bw_n = bw_q + 16'd1;
				else err_seen_n = 1'b1;
			end else if (mode_q == MODE_B64 && is_dash) begin
				if (!bits_ok) begin
					err_seen_n = 1'b1;
				end else begin
					mode_n = MODE_PLAIN; buf_n = '0; cnt_n = '0;
				end
			end else if (mode_q == MODE_AMP || mode_q == MODE_B64) begin
				// base64 digit
				mode_n = MODE_B64;
				buf_n  = base_buf;
				cnt_n  = base_cnt;
				if (!b64_ok) begin
					if (is_zero) begin
						mode_n = MODE_PLAIN; buf_n = '0; cnt_n = '0; bw_n = '0; err_seen_n = 1'b0;
					end else begin
						err_seen_n = 1'b1;
					end
				end else begin
					buf_n = new_buf;
					if (cp_full) begin
						cnt_n = 5'(new_cnt - 5'(CP_BITS));
						if (room_cp) bw_n = bw_q + 16'(cp_nb);
						else err_seen_n = 1'b1;
					end else begin
						cnt_n = new_cnt;
					end
				end
			end else begin
				// plain text
				if (is_zero) begin
					mode_n = MODE_PLAIN; buf_n = '0; cnt_n = '0; bw_n = '0; err_seen_n = 1'b0;
				end else if (is_ctl) begin
					err_seen_n = 1'b1;
				end else if (is_amp) begin
					mode_n = MODE_AMP;
				end else if (room_plain) begin
					bw_n = bw_q + 16'd1;
				end else begin
					err_seen_n = 1'b1;
				end
			end
		end
	end

	// Request to the back end
	always_comb begin
		push       = 1'b0;
		cmd.kind   = KIND_DATA;
		cmd.err    = ERR_CHAR;
		cmd.cp     = {8'h00, c};
		cmd.nbytes = 2'd1;
		if (accept && !err_seen_q) begin
			if (mode_q == MODE_AMP && is_dash) begin
				push   = 1'b1;
				cmd.cp = {8'h00, CH_AMP};
				if (!room_plain) begin
					cmd.kind = KIND_ERR; cmd.err = ERR_OVER;
				end
			end else if (mode_q == MODE_B64 && is_dash) begin
				if (!bits_ok) begin
					push = 1'b1; cmd.kind = KIND_ERR; cmd.err = ERR_BITS;
				end
			end else if (mode_q == MODE_AMP || mode_q == MODE_B64) begin
				if (!b64_ok) begin
					push = 1'b1; cmd.kind = KIND_ERR; cmd.err = ERR_B64;
				end else if (cp_full) begin
					push       = 1'b1;
					cmd.cp     = cp;
					cmd.nbytes = cp_nb;
					if (!room_cp) begin
						cmd.kind = KIND_ERR; cmd.err = ERR_OVER;
					end
				end
			end else begin
				if (is_zero) begin
					push     = 1'b1;
					cmd.kind = room_end ? KIND_END : KIND_ERR;
					cmd.err  = room_end ? ERR_CHAR : ERR_OVER;
				end else if (is_ctl) begin
					push = 1'b1; cmd.kind = KIND_ERR; cmd.err = ERR_CHAR;
				end else if (!is_amp) begin
					push = 1'b1;
					if (!room_plain) begin
						cmd.kind = KIND_ERR; cmd.err = ERR_OVER;
					end
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_PLAIN;
			buf_q      <= '0;
			cnt_q      <= '0;
			bw_q       <= '0;
			err_seen_q <= 1'b0;
			limit_q    <= 16'hFFFF;
		end else begin
			mode_q     <= mode_n;
			buf_q      <= buf_n;
			cnt_q      <= cnt_n;
			bw_q       <= bw_n;
			err_seen_q <= err_seen_n;
			if (cfg.valid) limit_q <= cfg.output_limit;
		end
	end

	// Checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 5'd15) else $error("bit count out of range");
	a_no_push_dropping: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !err_seen_q) else $error("request while dropping bytes");
	a_data_nbytes: assert property (@(posedge clk) disable iff (!arst_n)
		push && cmd.kind == KIND_DATA |-> cmd.nbytes != 2'd0)
		else $error("data request with no bytes");
	a_err_sets_drop: assert property (@(posedge clk) disable iff (!arst_n)
		push && cmd.kind == KIND_ERR && !is_zero |=> err_seen_q)
		else $error("error without drop state");

endmodule

>>> hw/rtl/mu7_queue.sv
// ----------------------------------------------------------------------------
// mu7_queue: request queue between front and back end
// Small register FIFO; the head is visible while not empty.
// ----------------------------------------------------------------------------
module mu7_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mu7_pkg::mu7_cmd_t wdata,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output mu7_pkg::mu7_cmd_t rdata
);
	import mu7_pkg::*;

	mu7_cmd_t              slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;

	assign full      = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = slots_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= wdata;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty)) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH)) else $error("fill count out of range");

endmodule

>>> hw/rtl/mu7_back.sv
// ----------------------------------------------------------------------------
// mu7_back: UTF-8 expansion and result register
// Walks the head request one output byte per cycle, unless stalled, into the result register.
// ----------------------------------------------------------------------------
module mu7_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  mu7_pkg::mu7_cmd_t cmd,
	output logic              pop,
	mu7_res_if.source         result
);
	import mu7_pkg::*;

	logic [1:0]  idx_q;
	logic        valid_q;
	logic [7:0]  byte_q;
	mu7_kind_t   kind_q;
	mu7_err_t    err_q;
	logic        last_q;
	logic        head_last, load;

	assign head_last = (cmd.kind != KIND_DATA) || (idx_q == cmd.nbytes - 2'd1);
	assign load      = head_valid && (!valid_q || result.ready);
	assign pop       = load && head_last;

	assign result.valid      = valid_q;
	assign result.out_byte   = byte_q;
	assign result.kind       = kind_q;
	assign result.error_code = err_q;
	assign result.last       = last_q;

	// Control: output valid and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= head_last ? 2'd0 : idx_q + 2'd1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= (cmd.kind == KIND_DATA) ? mu7_utf8_byte(cmd.cp, cmd.nbytes, idx_q)
				: 8'h00;
			kind_q <= cmd.kind;
			err_q  <= (cmd.kind == KIND_ERR) ? cmd.err : ERR_CHAR;
			last_q <= head_last;
		end
	end

	// Checks
	a_mid_seq_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> head_valid && cmd.kind == KIND_DATA)
		else $error("byte index set without data request");
	a_mark_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && kind_q != KIND_DATA |-> last_q)
		else $error("end or error result not marked last");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && cmd.kind == KIND_DATA |-> idx_q < cmd.nbytes)
		else $error("byte index past request length");

endmodule

>>> hw/rtl/modified_utf7_decoder_top.sv
// ----------------------------------------------------------------------------
// modified_utf7_decoder_top: IMAP modified UTF-7 to UTF-8 decoder
// Byte stream in, UTF-8 bytes plus end and error marks out.
// ----------------------------------------------------------------------------
// Channels: text carries one input byte per request; result carries one
// output byte, its kind (data, end of string, error), an error code and a
// last flag on the final result of each input byte. cfg writes the output
// limit (reset 65535); write it only while the decoder is idle.
// Throughput: the front end takes one byte per cycle while the request
// queue has room. The back end sends one result per cycle while the result
// channel is ready; each request yields one to three results, and bytes
// that yield nothing push no request.
// Path: a request is written into the queue at the edge that accepts its
// input byte and moves into the result register once that register is
// free or its result is taken.
// Stalls: a stalled result holds in the result register while the queue
// fills; text.ready drops once the four-entry queue is full.
// Reset (arst_n low): decode state, queue and result register clear at
// once and the limit returns to 65535. No clearing pass is needed.
// ----------------------------------------------------------------------------
module modified_utf7_decoder_top (
	input  logic     clk,
	input  logic     arst_n,
	mu7_byte_if.sink text,
	mu7_cfg_if.sink  cfg,
	mu7_res_if.source result
);
	import mu7_pkg::*;

	mu7_cmd_t push_cmd, head_cmd;
	logic     push, full, pop, head_valid;

	// Front end: classify and track decode state
	mu7_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.cfg    (cfg),
		.full   (full),
		.push   (push),
		.cmd    (push_cmd)
	);

	// Request queue
	mu7_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (push_cmd),
		.full      (full),
		.pop       (pop),
		.not_empty (head_valid),
		.rdata     (head_cmd)
	);

	// Back end: UTF-8 expansion
	mu7_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.cmd        (head_cmd),
		.pop        (pop),
		.result     (result)
	);

endmodule

>>> tb/sv/modified_utf7_decoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modified_utf7_decoder_top_tb: regression for the modified UTF-7 decoder
// Drives strings of modified UTF-7 into the text channel with bursty timing,
// stalls the result channel on a rotating pattern, and checks every UTF-8
// byte, end mark and error against an in-bench decoder. Directed strings
// hit the special cases; random strings, mostly well formed, run under
// several output limits.
// ----------------------------------------------------------------------------
module modified_utf7_decoder_top_tb;
	import mu7_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] out_byte;
		mu7_kind_t  kind;
		mu7_err_t   error_code;
		logic       last;
	} utf8_res_t;

	logic clk;
	logic arst_n;

	mu7_byte_if text_if();
	mu7_cfg_if  cfg_if();
	mu7_res_if  res_if();

	modified_utf7_decoder_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.cfg    (cfg_if),
		.result (res_if)
	);

	// Decoder state as the bench sees it
	mu7_mode_t   dec_mode;
	logic [21:0] dec_bits;
	int          dec_nbits;
	int          dec_written;
	bit          dec_dropping;
	logic [15:0] dec_limit;

	// Results of the byte being decoded, then all results still owed
	utf8_res_t   step_q[$];
	utf8_res_t   utf8_expect_q[$];

	int fail_count;
	int total_items;
	int useful_items;
	int data_cnt;
	int end_cnt;
	int err_cnt;
	int err_by_code[4];
	int cycle_cnt;
	int sender_burst;
	bit sender_calm;
	logic [8:0] rcv_tick;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// In-bench decoder
	// ------------------------------------------------------------------
	function automatic void clear_string_state();
		dec_mode     = MODE_PLAIN;
		dec_bits     = '0;
		dec_nbits    = 0;
		dec_written  = 0;
		dec_dropping = 1'b0;
	endfunction

	function automatic void add_res(input logic [7:0] b, input mu7_kind_t k,
		input mu7_err_t code);
		utf8_res_t r;
		r.out_byte   = b;
		r.kind       = k;
		r.error_code = code;
		r.last       = 1'b0;
		step_q.push_back(r);
	endfunction

	// Error result; a string-ending error also clears the string state
	function automatic void flag_error(input mu7_err_t code, input bit ends);
		add_res(8'h00, KIND_ERR, code);
		if (ends) begin
			clear_string_state();
		end else begin
			dec_dropping = 1'b1;
		end
	endfunction

	function automatic int b64_digit(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return int'(c) - int'("A");
		if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
		if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
		if (c == CH_PLUS) return 62;
		if (c == CH_COMMA) return 63;
		return -1;
	endfunction

	// One plain byte, room left for the terminator
	function automatic void take_plain(input logic [7:0] c);
		if (dec_written + 1 >= int'(dec_limit)) begin
			flag_error(ERR_OVER, 1'b0);
		end else begin
			add_res(c, KIND_DATA, ERR_CHAR);
			dec_written++;
		end
	endfunction

	// One base64 digit; every 16 bits give a code point in UTF-8
	function automatic void take_b64(input logic [7:0] c);
		int          v;
		int          nb;
		logic [15:0] cp;
		v = b64_digit(c);
		if (v < 0) begin
			flag_error(ERR_B64, c == 8'h00);
			return;
		end
		dec_bits = {dec_bits[15:0], 6'(v)};
		dec_nbits += 6;
		if (dec_nbits < 16) return;
		cp = 16'(dec_bits >> (dec_nbits - 16));
		dec_nbits -= 16;
		nb = (cp < 16'h0080) ? 1 : ((cp < 16'h0800) ? 2 : 3);
		if (dec_written + nb + 1 >= int'(dec_limit)) begin
			flag_error(ERR_OVER, 1'b0);
			return;
		end
		case (nb)
			1: begin
				add_res(cp[7:0], KIND_DATA, ERR_CHAR);
			end
			2: begin
				add_res({3'b110, cp[10:6]}, KIND_DATA, ERR_CHAR);
				add_res({2'b10, cp[5:0]}, KIND_DATA, ERR_CHAR);
			end
			default: begin
				add_res({4'b1110, cp[15:12]}, KIND_DATA, ERR_CHAR);
				add_res({2'b10, cp[11:6]}, KIND_DATA, ERR_CHAR);
				add_res({2'b10, cp[5:0]}, KIND_DATA, ERR_CHAR);
			end
		endcase
		dec_written += nb;
	endfunction

	// Decode one accepted byte and queue what it should produce
	function automatic void predict_byte(input logic [7:0] c);
		if (dec_dropping) begin
			if (c == 8'h00) clear_string_state();
			return;
		end
		case (dec_mode)
			MODE_AMP: begin
				if (c == CH_DASH) begin
					dec_mode = MODE_PLAIN;
					take_plain(CH_AMP);
				end else begin
					dec_mode  = MODE_B64;
					dec_bits  = '0;
					dec_nbits = 0;
					take_b64(c);
				end
			end
			MODE_B64: begin
				if (c == CH_DASH) begin
					// leftover bits must be zero
					if ((dec_bits & ((22'd1 << dec_nbits) - 22'd1)) != '0) begin
						flag_error(ERR_BITS, 1'b0);
					end else begin
						dec_mode  = MODE_PLAIN;
						dec_bits  = '0;
						dec_nbits = 0;
					end
				end else begin
					take_b64(c);
				end
			end
			default: begin
				if (c == 8'h00) begin
					if (dec_written >= int'(dec_limit)) begin
						flag_error(ERR_OVER, 1'b1);
					end else begin
						add_res(8'h00, KIND_END, ERR_CHAR);
						clear_string_state();
					end
				end else if (c < CH_SPACE || c >= 8'h80) begin
					flag_error(ERR_CHAR, 1'b0);
				end else if (c == CH_AMP) begin
					dec_mode = MODE_AMP;
				end else begin
					take_plain(c);
				end
			end
		endcase
		// mark the final result of this byte and hand everything over
		if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
		foreach (step_q[i]) utf8_expect_q.push_back(step_q[i]);
		step_q.delete();
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------
	// One text request; bursts of random length with random gaps unless calm
	task automatic send_byte(input logic [7:0] c);
		int gap;
		gap = 0;
		if (sender_burst == 0) begin
			sender_burst = $urandom_range(1, 16);
			if (!sender_calm) gap = $urandom_range(0, 5);
		end
		sender_burst--;
		@(negedge clk);
		if (gap > 0) begin
			text_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_if.valid   <= 1'b1;
		text_if.in_byte <= c;
		do @(posedge clk); while (!(text_if.valid === 1'b1 && text_if.ready === 1'b1));
		total_items++;
		if (!dec_dropping) useful_items++;
		predict_byte(c);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// Stop sending and let every owed result come out
	task automatic drain_decoder();
		@(negedge clk);
		text_if.valid <= 1'b0;
		while (utf8_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Limit register write; decoder must be idle
	task automatic write_limit(input logic [15:0] lim);
		@(negedge clk);
		cfg_if.valid        <= 1'b1;
		cfg_if.output_limit <= lim;
		do @(posedge clk); while (!(cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1));
		dec_limit = lim;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Result side stalls on a rotating pattern; first quarter never stalls
	always @(negedge clk) begin
		rcv_tick <= rcv_tick + 9'd1;
		case (rcv_tick[8:7])
			2'd0:    res_if.ready <= 1'b1;
			2'd1:    res_if.ready <= ($urandom_range(0, 3) != 0);
			2'd2:    res_if.ready <= ($urandom_range(0, 1) != 0);
			default: res_if.ready <= (rcv_tick[2:0] != 3'd0);
		endcase
	end

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		utf8_res_t want;
		if (arst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (utf8_expect_q.size() == 0) begin
				$display("%0t: unexpected result byte %02h kind %0d code %0d last %0d",
					$time, res_if.out_byte, res_if.kind, res_if.error_code, res_if.last);
				fail_count++;
			end else begin
				want = utf8_expect_q.pop_front();
				if (res_if.out_byte !== want.out_byte || res_if.kind !== want.kind ||
					res_if.error_code !== want.error_code || res_if.last !== want.last) begin
					$display("%0t: mismatch: expected byte %02h kind %0d code %0d last %0d",
						$time, want.out_byte, want.kind, want.error_code, want.last);
					$display("%0t:           got      byte %02h kind %0d code %0d last %0d",
						$time, res_if.out_byte, res_if.kind, res_if.error_code, res_if.last);
					fail_count++;
				end
				case (want.kind)
					KIND_DATA: data_cnt++;
					KIND_END:  end_cnt++;
					default: begin
						err_cnt++;
						err_by_code[want.error_code]++;
					end
				endcase
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still owed", $time, utf8_expect_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Random string pieces
	// ------------------------------------------------------------------
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		if (v < 6'd26) return 8'("A") + 8'(v);
		if (v < 6'd52) return 8'("a") + 8'(v - 6'd26);
		if (v < 6'd62) return 8'("0") + 8'(v - 6'd52);
		if (v == 6'd62) return CH_PLUS;
		return CH_COMMA;
	endfunction

	function automatic logic [15:0] random_code_point();
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(16'h0000, 16'h007F));
			1: return 16'($urandom_range(16'h0080, 16'h07FF));
			2, 3: return 16'($urandom_range(16'h0800, 16'hFFFF));
			default: begin
				case ($urandom_range(0, 5))
					0: return 16'h0000;
					1: return 16'h007F;
					2: return 16'h0080;
					3: return 16'h07FF;
					4: return 16'h0800;
					default: return 16'hFFFF;
				endcase
			end
		endcase
	endfunction

	// Properly encoded base64 run of ncp code points, zero padded
	task automatic send_b64_run(input int ncp);
		logic [63:0] acc;
		int          nbits;
		acc   = '0;
		nbits = 0;
		send_byte(CH_AMP);
		for (int k = 0; k < ncp; k++) begin
			acc = (acc << 16) | 64'(random_code_point());
			nbits += 16;
			while (nbits >= 6) begin
				send_byte(b64_char(6'(acc >> (nbits - 6))));
				nbits -= 6;
			end
		end
		if (nbits > 0) send_byte(b64_char(6'(acc << (6 - nbits))));
		send_byte(CH_DASH);
	endtask

	// Mostly well-formed pieces, some broken runs and stray bytes, then the end
	task automatic send_random_string();
		int  pieces;
		int  sel;
		int  len;
		logic [7:0] c;
		pieces = $urandom_range(1, 6);
		for (int p = 0; p < pieces; p++) begin
			sel = $urandom_range(0, 99);
			if (sel < 35) begin
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++) begin
					do c = 8'($urandom_range(8'h20, 8'h7F)); while (c == CH_AMP);
					send_byte(c);
				end
			end else if (sel < 45) begin
				send_text("&-");
			end else if (sel < 80) begin
				send_b64_run($urandom_range(1, 3));
			end else if (sel < 90) begin
				// broken run: random digits, odd close
				send_byte(CH_AMP);
				len = $urandom_range(0, 5);
				for (int i = 0; i < len; i++) send_byte(b64_char(6'($urandom_range(0, 63))));
				if ($urandom_range(0, 1)) send_byte(CH_DASH);
				else send_byte(8'($urandom_range(1, 255)));
			end else begin
				send_byte(8'($urandom_range(1, 255)));
			end
		end
		send_byte(8'h00);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Field extremes and the named special cases under the reset limit
	task automatic test_directed();
		send_byte(CH_SPACE);
		send_byte(8'h7F);
		send_text("&-");
		send_byte(8'h00);
		// two and three byte code points, then nonzero leftover bits
		send_text("&AOk-&,,8-&+++-");
		send_byte(8'h80);
		send_byte(8'h00);
		// zero code point, then zero byte inside a run
		send_text("&AAA");
		send_byte(8'h00);
		// control byte, dropped byte
		send_byte(8'h01);
		send_text("x");
		send_byte(8'h00);
		// zero byte right after the ampersand
		send_byte(CH_AMP);
		send_byte(8'h00);
		// bad digit after the ampersand
		send_text("&!");
		send_byte(8'h00);
		drain_decoder();
	endtask

	// Room checks for plain bytes, code points and the terminator
	task automatic test_overflow();
		write_limit(16'd2);
		send_text("ab");
		send_byte(8'h00);
		send_text("&AOk-");
		send_byte(8'h00);
		send_byte(8'h00);
		drain_decoder();
		write_limit(16'd4);
		send_text("&AOk-&AOk-");
		send_byte(8'h00);
		drain_decoder();
		// limit lowered under a string already in progress
		write_limit(16'hFFFF);
		send_text("abc");
		drain_decoder();
		write_limit(16'd2);
		send_byte(8'h00);
		drain_decoder();
	endtask

	// One limit setting, then random strings until quota input bytes
	task automatic run_limit_phase(input logic [15:0] lim, input int quota, input bit calm);
		int start;
		write_limit(lim);
		sender_calm = calm;
		start = total_items;
		while (total_items - start < quota) send_random_string();
		// pause until the decoder has caught up
		drain_decoder();
		sender_calm = 1'b0;
	endtask

	task automatic test_random();
		run_limit_phase(16'hFFFF, 50, 1'b0);
		run_limit_phase(16'd2, 30, 1'b0);
		run_limit_phase(16'($urandom_range(3, 16)), 45, 1'b0);
		run_limit_phase(16'($urandom_range(17, 16'hFFFF)), 45, 1'b1);
		run_limit_phase(16'($urandom_range(3, 40)), 45, 1'b0);
		run_limit_phase(16'hFFFF, 45, 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n              = 1'b0;
		text_if.valid       = 1'b0;
		text_if.in_byte     = 8'h00;
		cfg_if.valid        = 1'b0;
		cfg_if.output_limit = 16'h0000;
		res_if.ready        = 1'b0;
		rcv_tick            = '0;
		fail_count          = 0;
		total_items         = 0;
		useful_items        = 0;
		data_cnt            = 0;
		end_cnt             = 0;
		err_cnt             = 0;
		err_by_code         = '{default: 0};
		cycle_cnt           = 0;
		sender_burst        = 0;
		sender_calm         = 1'b0;
		dec_limit           = 16'hFFFF;
		clear_string_state();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_overflow();
		test_random();

		drain_decoder();
		repeat (8) @(posedge clk);
		if (utf8_expect_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, utf8_expect_q.size());
			fail_count++;
		end
		$display("Run covered %0d input bytes (%0d decoded) under limits from 2 to 65535.",
			total_items, useful_items);
		$display("Seen: %0d data, %0d ends, errors char/b64/bits/over %0d/%0d/%0d/%0d.",
			data_cnt, end_cnt, err_by_code[0], err_by_code[1], err_by_code[2],
			err_by_code[3]);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
